>>> src/ukst_pkg.sv
// Shared types and constants for the unique key stack.
// No dependencies; used by unique_key_stack_unit.
package ukst_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int KEY_W     = 32;
    localparam int KIND_W    = 2;
    localparam int STATUS_W  = 2;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH   = 2'd0,
        KIND_POP    = 2'd1,
        KIND_SEARCH = 2'd2
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE    = 2'd0,
        ST_PRESENT = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

endpackage

>>> src/ukst_ram.sv
// Generic single-write, single-read RAM with a registered read.
// No dependencies.
module ukst_ram #(
    parameter int W = 32,
    parameter int D = 16,
    localparam int AW = (D > 1) ? $clog2(D) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/unique_key_stack_unit.sv
// Unique key stack top level: request handshake, scan sequencer, result register.
// Depends on ukst_pkg and ukst_ram.
//
// A LIFO of signed 32-bit keys that holds each key at most once. Keys live in
// one RAM with a registered read; a push or search reads the stored entries
// from the bottom, one per cycle, and stops at the first match. The result
// appears on the output in the same cycle that the next request can be taken.
// One request is worked on at a time; a new request is taken while the
// previous result still waits on the output, and a finished request holds in
// its last cycle while that result is not yet taken. Every result carries the
// entry count after the request.
module unique_key_stack_unit #(
    parameter int DEPTH = ukst_pkg::DEPTH_DEF,
    localparam int CW     = $clog2(DEPTH + 1),
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int OUT_DW = ((1 + ukst_pkg::KEY_W + CW + 7) / 8) * 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [ukst_pkg::KEY_W-1:0]  s_axis_tdata,  // [31:0] key
    input  logic [ukst_pkg::KIND_W-1:0] s_axis_tuser,  // [1:0] kind
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [OUT_DW-1:0]           m_axis_tdata,  // found, popped_key, entry_count, zero pad
    output logic [ukst_pkg::STATUS_W-1:0] m_axis_tuser // [1:0] status
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    t_state                      r_state;
    logic [CW-1:0]               r_count;
    logic [CW-1:0]               r_addr;
    logic                        r_rd_vld;
    logic                        r_found;
    ukst_pkg::t_kind             r_kind;
    logic [ukst_pkg::KEY_W-1:0]  r_key;

    logic                          r_out_vld;
    ukst_pkg::t_status             r_out_status;
    logic                          r_out_found;
    logic [ukst_pkg::KEY_W-1:0]    r_out_popped;
    logic [CW-1:0]                 r_out_count;

    logic                        req_fire;
    logic                        out_free;
    logic                        hit;
    logic                        n_found;
    logic                        scan_more;
    logic                        ram_we;
    logic                        ram_re;
    logic [AW-1:0]               ram_raddr;
    logic [ukst_pkg::KEY_W-1:0]  ram_rdata;
    logic                        is_full;
    logic                        is_empty;
    ukst_pkg::t_status           n_out_status;
    logic [ukst_pkg::KEY_W-1:0]  n_out_popped;
    logic [CW-1:0]               n_count;

    assign s_axis_tready = (r_state == S_IDLE);
    assign req_fire      = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_vld || m_axis_tready;
    assign is_full       = (r_count == CW'(DEPTH));
    assign is_empty      = (r_count == '0);

    assign hit       = r_rd_vld && (ram_rdata == r_key);
    assign n_found   = r_found || hit;
    assign scan_more = !n_found && (r_addr < r_count);

    assign ram_we = (r_state == S_DONE) && out_free && (r_kind == ukst_pkg::KIND_PUSH)
                    && !r_found && !is_full;

    always_comb begin
        ram_re    = 1'b0;
        ram_raddr = '0;
        if (req_fire) begin
            if (ukst_pkg::t_kind'(s_axis_tuser) == ukst_pkg::KIND_POP) begin
                ram_re    = !is_empty;
                ram_raddr = AW'(r_count - CW'(1));
            end else begin
                ram_re    = !is_empty;
                ram_raddr = '0;
            end
        end else if (r_state == S_SCAN) begin
            ram_re    = scan_more;
            ram_raddr = r_addr[AW-1:0];
        end
    end

    always_comb begin
        n_out_status = ukst_pkg::ST_DONE;
        n_out_popped = '0;
        n_count      = r_count;
        case (r_kind)
            ukst_pkg::KIND_PUSH: begin
                if (r_found) begin
                    n_out_status = ukst_pkg::ST_PRESENT;
                end else if (is_full) begin
                    n_out_status = ukst_pkg::ST_FULL;
                end else begin
                    n_count = r_count + CW'(1);
                end
            end
            ukst_pkg::KIND_POP: begin
                if (is_empty) begin
                    n_out_status = ukst_pkg::ST_EMPTY;
                end else begin
                    n_count      = r_count - CW'(1);
                    n_out_popped = ram_rdata;
                end
            end
            default: begin
            end
        endcase
    end

    ukst_ram #(
        .W (ukst_pkg::KEY_W),
        .D (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (r_key),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            // in S_DONE a taken result is always replaced by the new one
            if (m_axis_tvalid && m_axis_tready && (r_state != S_DONE)) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (req_fire) begin
                        r_kind   <= ukst_pkg::t_kind'(s_axis_tuser);
                        r_key    <= s_axis_tdata;
                        r_found  <= 1'b0;
                        r_addr   <= CW'(1);
                        r_rd_vld <= !is_empty;
                        if (ukst_pkg::t_kind'(s_axis_tuser) == ukst_pkg::KIND_PUSH ||
                            ukst_pkg::t_kind'(s_axis_tuser) == ukst_pkg::KIND_SEARCH) begin
                            r_state <= S_SCAN;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_SCAN: begin
                    r_found <= n_found;
                    if (scan_more) begin
                        r_addr   <= r_addr + CW'(1);
                        r_rd_vld <= 1'b1;
                    end else begin
                        r_rd_vld <= 1'b0;
                        r_state  <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_vld    <= 1'b1;
                        r_out_found  <= r_found;
                        r_out_popped <= n_out_popped;
                        r_out_status <= n_out_status;
                        r_out_count  <= n_count;
                        r_count      <= n_count;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = OUT_DW'({r_out_count, r_out_popped, r_out_found});

endmodule

>>> test/tb_unique_key_stack_unit.sv
// Testbench for unique_key_stack_unit: directed and random push, pop and search requests
// checked against a local stack predictor, under random stalls and a long output hold-off.
// Depends on ukst_pkg and unique_key_stack_unit.
module tb_unique_key_stack_unit;

    localparam int DEPTH          = ukst_pkg::DEPTH_DEF;
    localparam int CNT_W          = $clog2(DEPTH + 1);
    localparam int OUT_W          = ((1 + ukst_pkg::KEY_W + CNT_W + 7) / 8) * 8;
    localparam logic [ukst_pkg::KIND_W-1:0] KIND_UNDEF = 2'd3;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int STALL_LIMIT    = 3000;
    localparam int TAIL_CYCLES    = DEPTH + 12;

    typedef struct packed {
        ukst_pkg::t_status             status;
        logic                          found;
        logic [ukst_pkg::KEY_W-1:0]    popped;
        logic [CNT_W-1:0]              count;
    } t_stack_result;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [ukst_pkg::KEY_W-1:0]      s_axis_tdata = '0;   // [31:0] key
    logic [ukst_pkg::KIND_W-1:0]     s_axis_tuser = '0;   // [1:0] kind
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [OUT_W-1:0]                m_axis_tdata;  // [0] found, [32:1] popped_key, [37:33] entry_count
    logic [ukst_pkg::STATUS_W-1:0]   m_axis_tuser;  // [1:0] status

    // predictor state
    logic [ukst_pkg::KEY_W-1:0]   stack_keys [DEPTH];
    int                           stack_depth = 0;
    t_stack_result                awaited_q [$];

    int  mismatches = 0;
    int  burst_left = 0;
    int  tx_gap_max = 0;
    int  rx_mode = 0;
    bit  rx_hold_req = 1'b0;
    int  rx_hold_left = 0;
    int  rx_phase = 0;
    int  idle_cycles = 0;

    unique_key_stack_unit #(.DEPTH(DEPTH)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #2 i_clk = ~i_clk;

    function automatic t_stack_result apply_stack_op(logic [ukst_pkg::KIND_W-1:0] kind,
                                                     logic [ukst_pkg::KEY_W-1:0] key);
        t_stack_result r;
        bit            hit;
        r = '{status: ukst_pkg::ST_DONE, found: 1'b0, popped: '0, count: '0};
        hit = 1'b0;
        for (int i = 0; i < stack_depth; i++)
            if (stack_keys[i] == key)
                hit = 1'b1;
        case (kind)
            ukst_pkg::KIND_PUSH: begin
                r.found = hit;
                if (hit) begin
                    r.status = ukst_pkg::ST_PRESENT;
                end else if (stack_depth >= DEPTH) begin
                    r.status = ukst_pkg::ST_FULL;
                end else begin
                    stack_keys[stack_depth] = key;
                    stack_depth++;
                end
            end
            ukst_pkg::KIND_POP: begin
                if (stack_depth == 0) begin
                    r.status = ukst_pkg::ST_EMPTY;
                end else begin
                    stack_depth--;
                    r.popped = stack_keys[stack_depth];
                end
            end
            ukst_pkg::KIND_SEARCH: r.found = hit;
            default: ;
        endcase
        r.count = CNT_W'(stack_depth);
        return r;
    endfunction

    // called at a rising edge; returns at the edge the request is taken, or after the idle gap that may follow it
    task automatic send_req(logic [ukst_pkg::KIND_W-1:0] kind,
                            logic [ukst_pkg::KEY_W-1:0] key);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= key;
        do @(posedge i_clk); while (!s_axis_tready);
        awaited_q.push_back(apply_stack_op(kind, key));
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 12);
            if (tx_gap_max > 0) begin
                gap = $urandom_range(1, tx_gap_max);
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic tx_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain_results();
        tx_idle();
        while (awaited_q.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic logic [ukst_pkg::KEY_W-1:0] pick_key();
        case ($urandom_range(0, 9))
            0, 1, 2: begin
                if (stack_depth > 0)
                    return stack_keys[$urandom_range(0, stack_depth - 1)];
                return $urandom;
            end
            3, 4, 5: return ukst_pkg::KEY_W'($urandom_range(0, 20)) - ukst_pkg::KEY_W'(6);
            6: begin
                case ($urandom_range(0, 3))
                    0: return 32'h8000_0000;
                    1: return 32'h7fff_ffff;
                    2: return 32'hffff_ffff;
                    default: return 32'h0000_0000;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [ukst_pkg::KIND_W-1:0] pick_kind(int w_push, int w_pop,
                                                              int w_search);
        int r;
        r = $urandom_range(0, w_push + w_pop + w_search + 1);
        if (r < w_push)
            return ukst_pkg::KIND_PUSH;
        if (r < w_push + w_pop)
            return ukst_pkg::KIND_POP;
        if (r < w_push + w_pop + w_search)
            return ukst_pkg::KIND_SEARCH;
        return KIND_UNDEF;
    endfunction

    task automatic test_directed();
        rx_mode = 0;
        tx_gap_max = 0;
        send_req(ukst_pkg::KIND_POP, 32'h0);
        send_req(ukst_pkg::KIND_SEARCH, 32'h0);
        send_req(KIND_UNDEF, 32'hdead_beef);
        send_req(ukst_pkg::KIND_PUSH, 32'h8000_0000);
        send_req(ukst_pkg::KIND_PUSH, 32'h7fff_ffff);
        send_req(ukst_pkg::KIND_PUSH, 32'h0000_0000);
        send_req(ukst_pkg::KIND_PUSH, 32'hffff_ffff);
        send_req(ukst_pkg::KIND_SEARCH, 32'h7fff_ffff);
        send_req(ukst_pkg::KIND_PUSH, 32'h7fff_ffff);
        for (int i = 0; i < DEPTH - 4; i++)
            send_req(ukst_pkg::KIND_PUSH, 32'(100 + i));
        send_req(ukst_pkg::KIND_PUSH, 32'h5555_aaaa);
        send_req(ukst_pkg::KIND_PUSH, 32'h8000_0000);
        send_req(KIND_UNDEF, 32'h0);
        send_req(ukst_pkg::KIND_POP, 32'hffff_ffff);
        drain_results();
    endtask

    task automatic test_random_mix();
        for (int seg = 0; seg < 6; seg++) begin
            rx_mode = seg % 4;
            tx_gap_max = (seg == 2) ? 0 : $urandom_range(1, 10);
            repeat (25)
                send_req(pick_kind(4, 3, 3), pick_key());
        end
        tx_idle();
    endtask

    task automatic test_fill_drain();
        int n;
        for (int round = 0; round < 4; round++) begin
            rx_mode = $urandom_range(0, 3);
            tx_gap_max = (round == 1) ? 0 : 6;
            n = 0;
            while (stack_depth < DEPTH && n < 40) begin
                if ($urandom_range(0, 3) == 0)
                    send_req(ukst_pkg::KIND_SEARCH, pick_key());
                else
                    send_req(ukst_pkg::KIND_PUSH, pick_key());
                n++;
            end
            send_req(ukst_pkg::KIND_PUSH, $urandom);
            send_req(ukst_pkg::KIND_PUSH, pick_key());
            while (stack_depth > 0) begin
                if ($urandom_range(0, 4) == 0)
                    send_req(ukst_pkg::KIND_SEARCH, pick_key());
                else
                    send_req(ukst_pkg::KIND_POP, $urandom);
            end
            send_req(ukst_pkg::KIND_POP, $urandom);
        end
        tx_idle();
    endtask

    task automatic test_output_holdoff();
        tx_gap_max = 0;
        rx_mode = 1;
        rx_hold_req = 1'b1;
        repeat (40)
            send_req(pick_kind(5, 2, 3), pick_key());
        drain_results();
    endtask

    task automatic test_quiet_restart();
        rx_mode = 2;
        tx_gap_max = 4;
        repeat (3) begin
            repeat (20)
                send_req(pick_kind(3, 3, 3), pick_key());
            drain_results();
        end
    endtask

    // receiver ready pattern and long hold-off
    always @(posedge i_clk) begin
        if (rx_hold_req) begin
            rx_hold_left = RX_HOLD_CYCLES;
            rx_hold_req = 1'b0;
        end
        rx_phase = (rx_phase + 1) % 5;
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            case (rx_mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= $urandom_range(0, 1);
                2: m_axis_tready <= (rx_phase == 0 || rx_phase == 3);
                default: m_axis_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        t_stack_result want;
        t_stack_result got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.status = ukst_pkg::t_status'(m_axis_tuser);
            got.found  = m_axis_tdata[0];
            got.popped = m_axis_tdata[ukst_pkg::KEY_W:1];
            got.count  = m_axis_tdata[ukst_pkg::KEY_W+CNT_W:ukst_pkg::KEY_W+1];
            if (awaited_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result with no request pending: %s status=%0d found=%0d",
                             "", got.status, got.found,
                             " popped=%h count=%0d", got.popped, got.count);
            end else begin
                want = awaited_q.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"result mismatch: expected status=%0d found=%0d",
                                  " popped=%h count=%0d, got status=%0d found=%0d",
                                  " popped=%h count=%0d"},
                                 want.status, want.found, want.popped, want.count,
                                 got.status, got.found, got.popped, got.count);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_mix();
        test_fill_drain();
        test_output_holdoff();
        test_quiet_restart();
        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && awaited_q.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
